// ===== hw/rtl/r2h_pkg.sv =====
// ----------------------------------------------------------------------------
// r2h_pkg: shared types and constants for the RGB to HSV converter
// Holds the divider widths, the hue sector codes and the word that the
// front end hands to the two divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package r2h_pkg;

  // channel and result widths
  localparam int CHAN_W = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int HUE_W = 16;
  localparam int SAT_W = 16;

  // divider: remainder/divisor width covers 6*d up to 1530
  localparam int DIV_W = 11;
  localparam int QUO_W = 16;
  localparam int DIV_BPS_DEF = 2;

  // largest-channel sector, ties go to red then green
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } r2h_sector_t;

  // word from the front end to the divider pipelines
  typedef struct packed {
    logic [DIV_W-1:0]  hue_rem;
    logic [DIV_W-1:0]  hue_div;
    logic [DIV_W-1:0]  sat_rem;
    logic [QUO_W-1:0]  sat_low;
    logic [DIV_W-1:0]  sat_div;
    logic              grey;
    logic              black;
    logic [CHAN_W-1:0] brightness;
  } r2h_front_t;

endpackage

`default_nettype wire

// ===== hw/rtl/r2h_front.sv =====
// ----------------------------------------------------------------------------
// r2h_front: channel split, max/min and numerator setup
// Stage 1 finds the largest and smallest channel, the sector and the
// sector difference. Stage 2 builds the hue numerator N (wrapped into
// [0, 6d)) and the saturation dividend d*65535 for the divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [r2h_pkg::COLOR_W-1:0]   in_color,
  output      logic                          out_vld,
  output      r2h_pkg::r2h_front_t           out_word
);

  localparam int CW = r2h_pkg::CHAN_W;
  localparam int DW = r2h_pkg::DIV_W;
  localparam int QW = r2h_pkg::QUO_W;
  localparam int AW = CW + QW;

  logic [CW-1:0] red, green, blue;
  logic [CW-1:0] mx_nxt, mn_nxt;
  r2h_pkg::r2h_sector_t sec_nxt;
  logic signed [CW:0] diff_nxt;

  logic                 s1_vld_r;
  logic [CW-1:0]        s1_mx_r;
  logic [CW-1:0]        s1_d_r;
  r2h_pkg::r2h_sector_t s1_sec_r;
  logic signed [CW:0]   s1_diff_r;

  logic [CW-1:0] d_sub;

  logic signed [DW:0] six_d;
  logic signed [DW:0] base;
  logic signed [DW:0] n_raw;
  logic signed [DW:0] n_wrap;
  logic [AW-1:0]      sat_num;
  r2h_pkg::r2h_front_t word_nxt;

  logic                s2_vld_r;
  r2h_pkg::r2h_front_t s2_word_r;

  // stage 1: max, min, sector and sector difference
  assign red   = in_color[3*CW-1:2*CW];
  assign green = in_color[2*CW-1:CW];
  assign blue  = in_color[CW-1:0];

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_nxt  = r2h_pkg::SEC_RED;
      mx_nxt   = red;
      diff_nxt = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sec_nxt  = r2h_pkg::SEC_GREEN;
      mx_nxt   = green;
      diff_nxt = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_nxt  = r2h_pkg::SEC_BLUE;
      mx_nxt   = blue;
      diff_nxt = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mn_nxt = red;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
  end

  assign d_sub = mx_nxt - mn_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_mx_r   <= mx_nxt;
    s1_d_r    <= d_sub;
    s1_sec_r  <= sec_nxt;
    s1_diff_r <= diff_nxt;
  end

  // stage 2: hue numerator with wrap, saturation dividend
  assign six_d = $signed({{(DW-CW-1){1'b0}}, s1_d_r, 2'b00})
               + $signed({{(DW-CW){1'b0}}, s1_d_r, 1'b0});

  always_comb begin
    unique case (s1_sec_r)
      r2h_pkg::SEC_RED:   base = '0;
      r2h_pkg::SEC_GREEN: base = $signed({{(DW-CW){1'b0}}, s1_d_r, 1'b0});
      r2h_pkg::SEC_BLUE:  base = $signed({{(DW-CW-1){1'b0}}, s1_d_r, 2'b00});
      default:            base = '0;
    endcase
  end

  assign n_raw  = base + $signed({{(DW-CW){s1_diff_r[CW]}}, s1_diff_r});
  assign n_wrap = n_raw[DW] ? (n_raw + six_d) : n_raw;

  // d*65535 = d*65536 - d; its top byte is d-1 for d > 0, always below max
  assign sat_num = {s1_d_r, {QW{1'b0}}} - {{QW{1'b0}}, s1_d_r};

  always_comb begin
    word_nxt.hue_rem    = n_wrap[DW-1:0];
    word_nxt.hue_div    = six_d[DW-1:0];
    word_nxt.sat_rem    = {{(DW-CW){1'b0}}, sat_num[AW-1:QW]};
    word_nxt.sat_low    = sat_num[QW-1:0];
    word_nxt.sat_div    = {{(DW-CW){1'b0}}, s1_mx_r};
    word_nxt.grey       = (s1_d_r == '0);
    word_nxt.black      = (s1_mx_r == '0);
    word_nxt.brightness = s1_mx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_word_r <= word_nxt;
  end

  assign out_vld  = s2_vld_r;
  assign out_word = s2_word_r;

endmodule

`default_nettype wire

// ===== hw/rtl/r2h_div.sv =====
// ----------------------------------------------------------------------------
// r2h_div: pipelined restoring divider
// Quotient of {rem, low} / div where rem < div on entry. Each stage
// retires BPS quotient bits; a sideband word rides along with the valid.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_div #(
  parameter int DW  = 11,
  parameter int QW  = 16,
  parameter int BPS = 2,
  parameter int SBW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_vld,
  input  wire logic [DW-1:0]  in_rem,
  input  wire logic [DW-1:0]  in_div,
  input  wire logic [QW-1:0]  in_low,
  input  wire logic [SBW-1:0] in_sb,
  output      logic           out_vld,
  output      logic [QW-1:0]  out_quo,
  output      logic [SBW-1:0] out_sb
);

  localparam int STAGES = QW / BPS;

  logic           vld_r [STAGES];
  logic [DW-1:0]  rem_r [STAGES];
  logic [DW-1:0]  div_r [STAGES];
  logic [QW-1:0]  low_r [STAGES];
  logic [QW-1:0]  quo_r [STAGES];
  logic [SBW-1:0] sb_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic           src_vld;
    logic [DW-1:0]  src_rem;
    logic [DW-1:0]  src_div;
    logic [QW-1:0]  src_low;
    logic [QW-1:0]  src_quo;
    logic [SBW-1:0] src_sb;
    logic [DW-1:0]  rem_nxt;
    logic [QW-1:0]  low_nxt;
    logic [QW-1:0]  quo_nxt;

    if (s == 0) begin : g_head
      assign src_vld = in_vld;
      assign src_rem = in_rem;
      assign src_div = in_div;
      assign src_low = in_low;
      assign src_quo = '0;
      assign src_sb  = in_sb;
    end else begin : g_body
      assign src_vld = vld_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_div = div_r[s-1];
      assign src_low = low_r[s-1];
      assign src_quo = quo_r[s-1];
      assign src_sb  = sb_r[s-1];
    end

    // BPS shift/compare/subtract steps
    always_comb begin
      logic [DW:0] trial;
      rem_nxt = src_rem;
      low_nxt = src_low;
      quo_nxt = src_quo;
      for (int k = 0; k < BPS; k++) begin
        trial   = {rem_nxt, low_nxt[QW-1]};
        low_nxt = {low_nxt[QW-2:0], 1'b0};
        if (trial >= {1'b0, src_div}) begin
          trial   = trial - {1'b0, src_div};
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
        rem_nxt = trial[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      div_r[s] <= src_div;
      low_r[s] <= low_nxt;
      quo_r[s] <= quo_nxt;
      sb_r[s]  <= src_sb;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_quo = quo_r[STAGES-1];
  assign out_sb  = sb_r[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit: pipelined RGB to HSV pixel converter
// Drive start with a pixel on in_packed_color (red 23..16, green 15..8,
// blue 7..0); busy stays low, so a pixel word is taken on every cycle
// that start is high. One result word per pixel appears on out_hue,
// out_saturation and out_brightness, marked by out_valid for one cycle,
// in input order.
// Throughput: one pixel per cycle. Latency is set by the two pipelined
// dividers (hue and saturation run side by side), each retiring
// DIV_BITS_PER_STAGE quotient bits per stage, plus two front stages and
// the output register.
// Reset (rst_n low, synchronous) drops every word in flight; no result
// from before reset comes out. The receiver cannot stall: every result
// is presented exactly once and must be taken in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_unit #(
  parameter int DIV_BITS_PER_STAGE = r2h_pkg::DIV_BPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [r2h_pkg::COLOR_W-1:0]  in_packed_color,
  output      logic                         out_valid,
  output      logic [r2h_pkg::HUE_W-1:0]    out_hue,
  output      logic [r2h_pkg::SAT_W-1:0]    out_saturation,
  output      logic [r2h_pkg::CHAN_W-1:0]   out_brightness
);

  localparam int CW = r2h_pkg::CHAN_W;
  localparam int DW = r2h_pkg::DIV_W;
  localparam int QW = r2h_pkg::QUO_W;
  localparam int HUE_SBW = CW + 1;
  localparam int LATENCY = 3 + QW / DIV_BITS_PER_STAGE;

  logic                in_accept;
  logic                fr_vld;
  r2h_pkg::r2h_front_t fr_word;

  logic               hue_vld;
  logic [QW-1:0]      hue_quo;
  logic [HUE_SBW-1:0] hue_sb;
  logic               sat_vld;
  logic [QW-1:0]      sat_quo;
  logic               sat_black;

  logic                valid_r;
  logic [QW-1:0]       hue_r;
  logic [QW-1:0]       sat_r;
  logic [CW-1:0]       bright_r;

  // pipeline never backs up
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // front end: max/min, sector, numerators
  r2h_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_accept),
    .in_color (in_packed_color),
    .out_vld  (fr_vld),
    .out_word (fr_word)
  );

  // hue: N*65536 / 6d, carries grey flag and brightness
  r2h_div #(
    .DW  (DW),
    .QW  (QW),
    .BPS (DIV_BITS_PER_STAGE),
    .SBW (HUE_SBW)
  ) u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_rem  (fr_word.hue_rem),
    .in_div  (fr_word.hue_div),
    .in_low  ({QW{1'b0}}),
    .in_sb   ({fr_word.grey, fr_word.brightness}),
    .out_vld (hue_vld),
    .out_quo (hue_quo),
    .out_sb  (hue_sb)
  );

  // saturation: d*65535 / max, carries black flag
  r2h_div #(
    .DW  (DW),
    .QW  (QW),
    .BPS (DIV_BITS_PER_STAGE),
    .SBW (1)
  ) u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_rem  (fr_word.sat_rem),
    .in_div  (fr_word.sat_div),
    .in_low  (fr_word.sat_low),
    .in_sb   (fr_word.black),
    .out_vld (sat_vld),
    .out_quo (sat_quo),
    .out_sb  (sat_black)
  );

  // output register; grey forces hue 0, black forces saturation 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= hue_vld;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_sb[CW] ? '0 : hue_quo;
    sat_r    <= sat_black ? '0 : sat_quo;
    bright_r <= hue_sb[CW-1:0];
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

`ifndef SYNTHESIS
  // both divider pipelines stay in step
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    hue_vld == sat_vld)
    else $error("hue and saturation dividers out of step");

  // every result traces back to a word accepted at the pipeline input
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LATENCY))
    else $error("result without matching input word");

  // black pixel gives all-zero result
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_hue == '0 && out_saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation means grey, so hue must be zero
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> (out_hue == '0))
    else $error("grey pixel with nonzero hue");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for rgb_to_hsv_converter_unit
// Pixels are queued by an initial block and presented by a negedge driver.
// A posedge monitor predicts hue, saturation and brightness for every
// accepted pixel and checks each out_valid word against the oldest
// prediction. Sender idling changes from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int CHAN_W  = r2h_pkg::CHAN_W;
  localparam int COLOR_W = r2h_pkg::COLOR_W;
  localparam int HUE_W   = r2h_pkg::HUE_W;
  localparam int SAT_W   = r2h_pkg::SAT_W;

  // one pending pixel plus how the driver should present it
  typedef struct {
    logic [COLOR_W-1:0] color;
    int unsigned        idle_pct;
    bit                 drain;
  } pixel_item_t;

  // one predicted result word
  typedef struct {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  localparam int RANDOM_PIXELS = 750;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [COLOR_W-1:0] in_packed_color;
  logic out_valid;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_saturation;
  logic [CHAN_W-1:0] out_brightness;

  pixel_item_t pixel_q[$];
  hsv_t hsv_expected[$];
  logic taken = 1'b0;
  int unsigned fail_count = 0;

  rgb_to_hsv_converter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_packed_color(in_packed_color),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hue/saturation/value of one pixel, exact integer form
  function automatic hsv_t predict_hsv(logic [COLOR_W-1:0] px);
    int r, g, b, mx, mn, d, n;
    r2h_pkg::r2h_sector_t sec;
    hsv_t res;
    r = px[2*CHAN_W +: CHAN_W];
    g = px[CHAN_W +: CHAN_W];
    b = px[0 +: CHAN_W];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // ties resolve to red, then green
    if (r == mx) sec = r2h_pkg::SEC_RED;
    else if (g == mx) sec = r2h_pkg::SEC_GREEN;
    else sec = r2h_pkg::SEC_BLUE;
    res.hue = '0;
    res.saturation = '0;
    res.brightness = mx[CHAN_W-1:0];
    if (mx != 0) res.saturation = SAT_W'((d * 65535) / mx);
    // grey and black keep hue at zero
    if (d != 0) begin
      case (sec)
        r2h_pkg::SEC_RED:   n = g - b;
        r2h_pkg::SEC_GREEN: n = 2 * d + (b - r);
        default:            n = 4 * d + (r - g);
      endcase
      if (n < 0) n += 6 * d;
      res.hue = HUE_W'((n * 65536) / (6 * d));
    end
    return res;
  endfunction

  // random pixel, biased toward near-grey, tied and grey colors
  function automatic logic [COLOR_W-1:0] rand_pixel();
    int kind, base, ch[3];
    logic [CHAN_W-1:0] v;
    kind = $urandom_range(9);
    if (kind <= 5) return COLOR_W'($urandom);
    base = $urandom_range(255);
    for (int i = 0; i < 3; i++) begin
      ch[i] = base + $signed($urandom_range(6)) - 3;
      if (ch[i] < 0) ch[i] = 0;
      if (ch[i] > 255) ch[i] = 255;
    end
    if (kind == 8) begin
      // two channels tie, third random
      v = CHAN_W'($urandom);
      case ($urandom_range(2))
        0: return {CHAN_W'(base), CHAN_W'(base), v};
        1: return {CHAN_W'(base), v, CHAN_W'(base)};
        default: return {v, CHAN_W'(base), CHAN_W'(base)};
      endcase
    end
    if (kind == 9) return {3{CHAN_W'(base)}};
    return {CHAN_W'(ch[0]), CHAN_W'(ch[1]), CHAN_W'(ch[2])};
  endfunction

  function automatic pixel_item_t mk_item(logic [COLOR_W-1:0] c, int unsigned pct, bit dr);
    pixel_item_t it;
    it.color = c;
    it.idle_pct = pct;
    it.drain = dr;
    return it;
  endfunction

  // driver: presents queued pixels, holds until taken
  always @(negedge clk) begin : drive
    logic nxt_start;
    nxt_start = 1'b0;
    if (rst_n) begin
      if (start && !taken) begin
        nxt_start = 1'b1;
      end else if (pixel_q.size() != 0) begin
        if (pixel_q[0].drain && hsv_expected.size() != 0) begin
          nxt_start = 1'b0;
        end else if ($urandom_range(99) >= pixel_q[0].idle_pct) begin
          in_packed_color <= pixel_q[0].color;
          pixel_q.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: predict on accept, check on out_valid
  always @(posedge clk) begin : monitor
    hsv_t exp_w;
    if (rst_n) begin
      taken <= start && !busy;
      if (out_valid) begin
        if (hsv_expected.size() == 0) begin
          $error("unexpected result word: hue %0d sat %0d val %0d",
                 out_hue, out_saturation, out_brightness);
          fail_count++;
        end else begin
          exp_w = hsv_expected.pop_front();
          if (out_hue !== exp_w.hue) begin
            $error("hue: expected %0d, actual %0d", exp_w.hue, out_hue);
            fail_count++;
          end
          if (out_saturation !== exp_w.saturation) begin
            $error("saturation: expected %0d, actual %0d",
                   exp_w.saturation, out_saturation);
            fail_count++;
          end
          if (out_brightness !== exp_w.brightness) begin
            $error("brightness: expected %0d, actual %0d",
                   exp_w.brightness, out_brightness);
            fail_count++;
          end
        end
      end
      if (start && !busy) hsv_expected.push_back(predict_hsv(in_packed_color));
    end
  end

  // stimulus and end of run
  initial begin : stim
    logic [COLOR_W-1:0] directed[$];
    int unsigned phase_idle[3];
    phase_idle[0] = 27;
    phase_idle[1] = 70;
    phase_idle[2] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_packed_color = '0;

    // black, white, greys, primaries, ties, wraps, tiny spreads
    directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
                 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
                 24'h01FF00, 24'h00FF01, 24'h0100FF, 24'h0001FF,
                 24'h010000, 24'h000001, 24'hFEFFFF, 24'hFFFEFF,
                 24'h55AA55, 24'hAA55AA, 24'h123456, 24'hFEFEFF};
    foreach (directed[i]) pixel_q.push_back(mk_item(directed[i], 0, 1'b0));

    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < RANDOM_PIXELS / 3; i++) begin
        // pause for an empty pipeline at each phase change and mid-phase once
        pixel_q.push_back(mk_item(rand_pixel(), phase_idle[p],
                                  i == 0 || (p == 0 && i == 120)));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pixel_q.size() != 0 || (start && !taken) || hsv_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && hsv_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
